FILE: rtl/osd_screen_diff_spi_encoder_assert.svh
// Assertion helpers for the screen-difference encoder.
`ifndef OSD_SCREEN_DIFF_SPI_ENCODER_ASSERT_SVH
`define OSD_SCREEN_DIFF_SPI_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OSDE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("osde: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OSDE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("osde: assertion failed");

`endif

FILE: rtl/osde_pkg.sv
package osde_pkg;

	typedef struct packed {
		logic [2:0] command;
		logic [4:0] column;
		logic [4:0] row;
		logic [7:0] char_code;
	} osde_in_t;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       byte_valid;
		logic       last;
		logic       scan_wrapped;
	} osde_out_t;

	typedef enum logic [2:0] {
		CMD_WRITE      = 3'd0,
		CMD_SCAN       = 3'd1,
		CMD_END        = 3'd2,
		CMD_CLR_SHADOW = 3'd3,
		CMD_CLR_SCREEN = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_PAL_MODE     = 2'd0,
		CFG_ACTIVE_LAYER = 2'd1,
		CFG_MODE_BITS    = 2'd2
	} cfg_reg_t;

	// display register map
	localparam logic [7:0] REG_MODE     = 8'h04;
	localparam logic [7:0] REG_ADDR_HI  = 8'h05;
	localparam logic [7:0] REG_ADDR_LO  = 8'h06;
	localparam logic [7:0] REG_DATA     = 8'h07;
	localparam logic [7:0] AUTO_INC_BIT = 8'h01;
	localparam logic [7:0] END_MARK     = 8'hff;
	localparam logic [7:0] SPACE_CHAR   = 8'h20;

	typedef enum logic [3:0] {
		B_REG_MODE,
		B_MODE,
		B_MODE_AI,
		B_REG_HI,
		B_POS_HI,
		B_REG_LO,
		B_POS_LO,
		B_REG_DATA,
		B_END,
		B_CUR
	} bsel_t;

	typedef enum logic [2:0] {
		M_NONE,
		M_WR_CUR,
		M_WR_CHAR,
		M_FILL_LAYER,
		M_FILL_SHADOW,
		M_INIT
	} mem_op_t;

	typedef enum logic [2:0] {
		F_NONE,
		F_AI_NEXT,
		F_ADDR_DONE,
		F_NEED_ADDR,
		F_CLOSE,
		F_POS
	} flag_op_t;

	typedef enum logic [2:0] {
		J_NEVER,
		J_ALWAYS,
		J_NOT_DIFF,
		J_RUN_OPEN,
		J_NEED_ADDR,
		J_NOT_AI,
		J_NOT_WRAPPED
	} jcond_t;

	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_FLUSH,
		FIN_QUIET
	} fin_t;

	typedef enum logic {
		SQ_IDLE,
		SQ_RUN
	} seq_state_t;

	typedef logic [4:0] step_t;

	typedef struct packed {
		logic     emit;
		bsel_t    bsel;
		mem_op_t  mem;
		logic     rd_next;
		logic     latch_cur;
		logic     latch_nxt;
		logic     addr_inc;
		logic     rpt;
		flag_op_t fop;
		jcond_t   jc;
		step_t    target;
		fin_t     fin;
	} ucode_t;

	typedef struct packed {
		logic stall;
		logic diff;
		logic need_addr;
		logic auto_inc;
		logic wrapped;
		logic sweep_last;
	} osde_flags_t;

	typedef struct packed {
		logic adv;
		logic idle;
		logic finish;
	} osde_ctl_t;

	// program steps
	localparam step_t ST_SC_RD     = 5'd0;
	localparam step_t ST_SC_LATCH  = 5'd1;
	localparam step_t ST_SC_NEXT   = 5'd2;
	localparam step_t ST_SC_CHK    = 5'd3;
	localparam step_t ST_SC_MODE_R = 5'd4;
	localparam step_t ST_SC_MODE_V = 5'd5;
	localparam step_t ST_SC_HI_R   = 5'd6;
	localparam step_t ST_SC_HI_V   = 5'd7;
	localparam step_t ST_SC_LO_R   = 5'd8;
	localparam step_t ST_SC_LO_V   = 5'd9;
	localparam step_t ST_SC_DATA_R = 5'd10;
	localparam step_t ST_SC_DATA_V = 5'd11;
	localparam step_t ST_SC_SAME   = 5'd12;
	localparam step_t ST_SC_DROP   = 5'd13;
	localparam step_t ST_SC_FF_R   = 5'd14;
	localparam step_t ST_SC_FF_V   = 5'd15;
	localparam step_t ST_SC_END    = 5'd16;
	localparam step_t ST_CL        = 5'd17;
	localparam step_t ST_CL_CHK    = 5'd18;
	localparam step_t ST_CL_FF_R   = 5'd19;
	localparam step_t ST_CL_FF_V   = 5'd20;
	localparam step_t ST_CL_MODE_R = 5'd21;
	localparam step_t ST_CL_MODE_V = 5'd22;
	localparam step_t ST_CL_FIN    = 5'd23;
	localparam step_t ST_DONE      = 5'd24;
	localparam step_t ST_WR        = 5'd25;
	localparam step_t ST_CLR_SH    = 5'd26;
	localparam step_t ST_CLR_LY    = 5'd27;
	localparam step_t ST_INIT      = 5'd28;

	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w = '0;
		case (s)
			ST_SC_RD: begin
				w.rd_next = 1'b0;
			end
			ST_SC_LATCH: begin
				w.rd_next = 1'b1;
				w.latch_cur = 1'b1;
			end
			ST_SC_NEXT: begin
				w.latch_nxt = 1'b1;
				w.jc = J_NOT_DIFF;
				w.target = ST_SC_SAME;
			end
			ST_SC_CHK: begin
				w.jc = J_RUN_OPEN;
				w.target = ST_SC_DATA_R;
			end
			ST_SC_MODE_R: begin
				w.emit = 1'b1;
				w.bsel = B_REG_MODE;
			end
			ST_SC_MODE_V: begin
				w.emit = 1'b1;
				w.bsel = B_MODE_AI;
				w.fop = F_AI_NEXT;
			end
			ST_SC_HI_R: begin
				w.emit = 1'b1;
				w.bsel = B_REG_HI;
			end
			ST_SC_HI_V: begin
				w.emit = 1'b1;
				w.bsel = B_POS_HI;
			end
			ST_SC_LO_R: begin
				w.emit = 1'b1;
				w.bsel = B_REG_LO;
			end
			ST_SC_LO_V: begin
				w.emit = 1'b1;
				w.bsel = B_POS_LO;
				w.fop = F_ADDR_DONE;
			end
			ST_SC_DATA_R: begin
				w.emit = 1'b1;
				w.bsel = B_REG_DATA;
				w.mem = M_WR_CUR;
			end
			ST_SC_DATA_V: begin
				w.emit = 1'b1;
				w.bsel = B_CUR;
				w.jc = J_ALWAYS;
				w.target = ST_SC_END;
			end
			ST_SC_SAME: begin
				w.jc = J_NEED_ADDR;
				w.target = ST_SC_END;
			end
			ST_SC_DROP: begin
				w.fop = F_NEED_ADDR;
				w.jc = J_NOT_AI;
				w.target = ST_SC_END;
			end
			ST_SC_FF_R: begin
				w.emit = 1'b1;
				w.bsel = B_REG_DATA;
			end
			ST_SC_FF_V: begin
				w.emit = 1'b1;
				w.bsel = B_END;
			end
			ST_SC_END: begin
				w.fop = F_POS;
				w.jc = J_NOT_WRAPPED;
				w.target = ST_DONE;
			end
			ST_CL: begin
				w.jc = J_NOT_AI;
				w.target = ST_CL_FIN;
			end
			ST_CL_CHK: begin
				w.jc = J_NEED_ADDR;
				w.target = ST_CL_MODE_R;
			end
			ST_CL_FF_R: begin
				w.emit = 1'b1;
				w.bsel = B_REG_DATA;
			end
			ST_CL_FF_V: begin
				w.emit = 1'b1;
				w.bsel = B_END;
			end
			ST_CL_MODE_R: begin
				w.emit = 1'b1;
				w.bsel = B_REG_MODE;
			end
			ST_CL_MODE_V: begin
				w.emit = 1'b1;
				w.bsel = B_MODE;
			end
			ST_CL_FIN: begin
				w.fop = F_CLOSE;
			end
			ST_DONE: begin
				w.fin = FIN_FLUSH;
			end
			ST_WR: begin
				w.mem = M_WR_CHAR;
				w.fin = FIN_FLUSH;
			end
			ST_CLR_SH: begin
				w.mem = M_FILL_SHADOW;
				w.addr_inc = 1'b1;
				w.rpt = 1'b1;
				w.fin = FIN_FLUSH;
			end
			ST_CLR_LY: begin
				w.mem = M_FILL_LAYER;
				w.addr_inc = 1'b1;
				w.rpt = 1'b1;
				w.fin = FIN_FLUSH;
			end
			ST_INIT: begin
				w.mem = M_INIT;
				w.addr_inc = 1'b1;
				w.rpt = 1'b1;
				w.fin = FIN_QUIET;
			end
			default: begin
				w.fin = FIN_QUIET;
			end
		endcase
		return w;
	endfunction

	function automatic step_t cmd_entry(logic [2:0] c);
		step_t s;
		case (c)
			CMD_WRITE:      s = ST_WR;
			CMD_SCAN:       s = ST_SC_RD;
			CMD_END:        s = ST_CL;
			CMD_CLR_SHADOW: s = ST_CLR_SH;
			CMD_CLR_SCREEN: s = ST_CLR_LY;
			default:        s = ST_DONE;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/osde_useq.sv
module osde_useq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [2:0]             command,
	input  osde_pkg::osde_flags_t  flags,
	output osde_pkg::ucode_t       cw,
	output osde_pkg::osde_ctl_t    ctl
);
	import osde_pkg::*;

	seq_state_t state_q, state_d;
	step_t      step_q, step_d;
	logic       jump;
	logic       adv;
	logic       finish;

	assign cw     = ucode_rom(step_q);
	assign adv    = (state_q == SQ_RUN) && !flags.stall;
	assign finish = (cw.fin != FIN_NONE) && (!cw.rpt || flags.sweep_last);

	assign ctl.adv    = adv;
	assign ctl.idle   = (state_q == SQ_IDLE);
	assign ctl.finish = finish;

	always_comb begin
		case (cw.jc)
			J_NEVER:       jump = 1'b0;
			J_ALWAYS:      jump = 1'b1;
			J_NOT_DIFF:    jump = !flags.diff;
			J_RUN_OPEN:    jump = !flags.need_addr && flags.auto_inc;
			J_NEED_ADDR:   jump = flags.need_addr;
			J_NOT_AI:      jump = !flags.auto_inc;
			J_NOT_WRAPPED: jump = !flags.wrapped;
			default:       jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_RUN;
			step_q  <= ST_INIT;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			SQ_IDLE: begin
				if (start) begin
					state_d = SQ_RUN;
					step_d  = cmd_entry(command);
				end
			end
			SQ_RUN: begin
				if (adv) begin
					if (cw.rpt && !flags.sweep_last) begin
						step_d = step_q;
					end else if (finish) begin
						state_d = SQ_IDLE;
					end else if (jump) begin
						step_d = cw.target;
					end else begin
						step_d = step_q + 5'd1;
					end
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/osd_screen_diff_spi_encoder.sv
// Character OSD screen-difference encoder. Holds LAYER_COUNT character layers and a shadow of
// the display memory in on-chip RAM and turns commands into a stream of register/value bytes,
// one byte per output transfer, the final one flagged by last (an input that sends nothing
// gives one empty result). A microcoded sequencer runs one program step per clock while the
// output register does not stall it; a byte waits for as long as the output register is still
// occupied. Clear screen sweeps the layer one entry per cycle, held while the output register
// is occupied; clear shadow sweeps the current screen size. After reset the block clears all
// layers and the shadow with in_ready low; configuration writes are taken throughout.
module osd_screen_diff_spi_encoder #(
	parameter int COLUMNS     = 30,
	parameter int ROWS_TALL   = 16,
	parameter int ROWS_SHORT  = 13,
	parameter int LAYER_COUNT = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  osde_pkg::osde_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output osde_pkg::osde_out_t out_data,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata
);
	import osde_pkg::*;

	localparam int LAYER_SIZE = COLUMNS * ROWS_TALL;
	localparam int TOTAL      = LAYER_COUNT * LAYER_SIZE;
	localparam int SHORT_RAW  = ROWS_SHORT * COLUMNS;
	localparam int SIZE_SHORT = (SHORT_RAW > LAYER_SIZE) ? LAYER_SIZE : SHORT_RAW;
	localparam int POS_W      = (LAYER_SIZE > 1) ? $clog2(LAYER_SIZE) : 1;
	localparam int CNT_W      = $clog2(LAYER_SIZE + 1);
	localparam int ADDR_W     = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int LYR_W      = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;

	// configuration
	logic        pal_q;
	logic        layer_q;
	logic [7:0]  mode_bits_q;

	// scan state
	logic [POS_W-1:0] scan_pos_q;
	logic             need_addr_q;
	logic             ai_q;

	// per-item datapath
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        char_q;
	logic              wr_ok_q;
	logic              wrapped_q;
	logic [7:0]        cur_q;
	logic              diff_q;
	logic              next_diff_q;
	logic [7:0]        pend_q;
	logic              pend_v_q;
	osde_out_t         out_q;
	logic              out_v_q;

	// storage
	logic [7:0] lay_mem [TOTAL];
	logic [7:0] sh_mem [LAYER_SIZE];
	logic [7:0] lay_rd_q;
	logic [7:0] sh_rd_q;

	ucode_t      cw;
	osde_ctl_t   ctl;
	osde_flags_t flags;

	logic              accept;
	logic              out_free;
	logic              push_mid;
	logic              push_fin;
	logic [LYR_W-1:0]  layer_sel;
	logic [ADDR_W-1:0] layer_base;
	logic [CNT_W-1:0]  screen_size;
	logic [POS_W-1:0]  pos;
	logic [POS_W-1:0]  pos_inc;
	logic [15:0]       pos_wide;
	logic [POS_W-1:0]  rd_pos;
	logic [ADDR_W-1:0] rd_flat;
	logic              sweep_last;
	logic [7:0]        emit_byte;
	logic              lay_we;
	logic [ADDR_W-1:0] lay_wa;
	logic [7:0]        lay_wd;
	logic              sh_we;
	logic [POS_W-1:0]  sh_wa;
	logic [7:0]        sh_wd;

	assign accept   = in_valid && in_ready;
	assign in_ready = ctl.idle;
	assign out_free = !out_v_q || out_ready;

	assign layer_sel   = (32'(layer_q) < LAYER_COUNT) ? LYR_W'(layer_q) : '0;
	assign layer_base  = ADDR_W'(32'(layer_sel) * LAYER_SIZE);
	assign screen_size = pal_q ? CNT_W'(LAYER_SIZE) : CNT_W'(SIZE_SHORT);
	assign pos         = addr_q[POS_W-1:0];
	assign pos_inc     = pos + POS_W'(1);
	assign pos_wide    = 16'(pos);

	// lookahead past the screen end reads a harmless entry and is masked by wrapped_q
	assign rd_pos  = cw.rd_next ? (wrapped_q ? '0 : pos_inc) : pos;
	assign rd_flat = layer_base + ADDR_W'(rd_pos);

	always_comb begin
		case (cw.mem)
			M_FILL_SHADOW: sweep_last = (32'(addr_q) == 32'(screen_size) - 32'd1);
			M_FILL_LAYER:  sweep_last = (32'(addr_q) == LAYER_SIZE - 1);
			M_INIT:        sweep_last = (32'(addr_q) == TOTAL - 1);
			default:       sweep_last = 1'b1;
		endcase
	end

	assign flags.stall      = (cw.emit && pend_v_q && !out_free) ||
	                          ((cw.fin == FIN_FLUSH) && !out_free);
	assign flags.diff       = diff_q;
	assign flags.need_addr  = need_addr_q;
	assign flags.auto_inc   = ai_q;
	assign flags.wrapped    = wrapped_q;
	assign flags.sweep_last = sweep_last;

	osde_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.command (in_data.command),
		.flags   (flags),
		.cw      (cw),
		.ctl     (ctl)
	);

	always_comb begin
		case (cw.bsel)
			B_REG_MODE: emit_byte = REG_MODE;
			B_MODE:     emit_byte = mode_bits_q;
			B_MODE_AI:  emit_byte = mode_bits_q | (next_diff_q ? AUTO_INC_BIT : 8'h00);
			B_REG_HI:   emit_byte = REG_ADDR_HI;
			B_POS_HI:   emit_byte = pos_wide[15:8];
			B_REG_LO:   emit_byte = REG_ADDR_LO;
			B_POS_LO:   emit_byte = pos_wide[7:0];
			B_REG_DATA: emit_byte = REG_DATA;
			B_END:      emit_byte = END_MARK;
			B_CUR:      emit_byte = cur_q;
			default:    emit_byte = 8'h00;
		endcase
	end

	always_comb begin
		lay_we = 1'b0;
		lay_wa = layer_base + ADDR_W'(pos);
		lay_wd = SPACE_CHAR;
		sh_we  = 1'b0;
		sh_wa  = pos;
		sh_wd  = 8'h00;
		case (cw.mem)
			M_WR_CUR: begin
				lay_we = ctl.adv;
				lay_wd = cur_q;
				sh_we  = ctl.adv;
				sh_wd  = cur_q;
			end
			M_WR_CHAR: begin
				lay_we = ctl.adv && wr_ok_q;
				lay_wd = char_q;
			end
			M_FILL_LAYER: begin
				lay_we = ctl.adv;
			end
			M_FILL_SHADOW: begin
				sh_we = ctl.adv;
			end
			M_INIT: begin
				lay_we = ctl.adv;
				lay_wa = addr_q;
				sh_we  = ctl.adv && (32'(addr_q) < LAYER_SIZE);
			end
			default: begin
				lay_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lay_we) begin
			lay_mem[lay_wa] <= lay_wd;
		end
		lay_rd_q <= lay_mem[rd_flat];
	end

	always_ff @(posedge clk) begin
		if (sh_we) begin
			sh_mem[sh_wa] <= sh_wd;
		end
		sh_rd_q <= sh_mem[rd_pos];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_q       <= 1'b1;
			layer_q     <= 1'b0;
			mode_bits_q <= 8'h00;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PAL_MODE:     pal_q       <= cfg_wdata[0];
				CFG_ACTIVE_LAYER: layer_q     <= cfg_wdata[0];
				CFG_MODE_BITS:    mode_bits_q <= cfg_wdata;
				default:          pal_q       <= pal_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			wrapped_q   <= 1'b0;
			scan_pos_q  <= '0;
			need_addr_q <= 1'b1;
			ai_q        <= 1'b0;
		end else if (accept) begin
			wrapped_q <= 1'b0;
			case (in_data.command)
				CMD_SCAN: begin
					addr_q    <= ADDR_W'(scan_pos_q);
					wrapped_q <= (32'(scan_pos_q) + 32'd1 >= 32'(screen_size));
				end
				CMD_WRITE: begin
					addr_q <= ADDR_W'(32'(in_data.row) * COLUMNS + 32'(in_data.column));
				end
				default: begin
					addr_q <= '0;
				end
			endcase
		end else if (ctl.adv) begin
			if (cw.addr_inc) begin
				addr_q <= addr_q + ADDR_W'(1);
			end
			case (cw.fop)
				F_AI_NEXT:   ai_q        <= next_diff_q;
				F_ADDR_DONE: need_addr_q <= 1'b0;
				F_NEED_ADDR: need_addr_q <= 1'b1;
				F_CLOSE: begin
					ai_q        <= 1'b0;
					need_addr_q <= 1'b1;
				end
				F_POS:       scan_pos_q  <= wrapped_q ? '0 : pos_inc;
				default:     ai_q        <= ai_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q  <= in_data.char_code;
			wr_ok_q <= (32'(in_data.column) < COLUMNS) && (32'(in_data.row) < ROWS_TALL);
		end
		if (ctl.adv && cw.latch_cur) begin
			diff_q <= (lay_rd_q != sh_rd_q);
			// a stored end mark goes out, and back into the layer, as a space
			cur_q  <= (lay_rd_q == END_MARK) ? SPACE_CHAR : lay_rd_q;
		end
		if (ctl.adv && cw.latch_nxt) begin
			next_diff_q <= !wrapped_q && (lay_rd_q != sh_rd_q);
		end
	end

	// one byte is held back so the final byte of an item can carry last
	assign push_mid = ctl.adv && cw.emit && pend_v_q;
	assign push_fin = ctl.adv && ctl.finish && (cw.fin == FIN_FLUSH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (ctl.adv && cw.emit) begin
			pend_v_q <= 1'b1;
		end else if (push_fin) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && cw.emit) begin
			pend_q <= emit_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push_mid || push_fin) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_mid) begin
			out_q <= '{spi_byte: pend_q, byte_valid: 1'b1, last: 1'b0,
			           scan_wrapped: wrapped_q};
		end else if (push_fin) begin
			out_q <= '{spi_byte: pend_v_q ? pend_q : 8'h00, byte_valid: pend_v_q, last: 1'b1,
			           scan_wrapped: wrapped_q};
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

FILE: rtl/osde_checker.sv
`include "osd_screen_diff_spi_encoder_assert.svh"

module osde_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input osde_pkg::osde_out_t out_data
);
	logic out_xfer;

	assign out_xfer = out_valid && out_ready;

	// a stalled result holds
	`OSDE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	// an empty result always closes its item
	`OSDE_ASSERT_IMP(a_empty_last, clk, arst_n, out_xfer && !out_data.byte_valid, out_data.last)
	// every non-final result carries a byte
	`OSDE_ASSERT_IMP(a_mid_byte, clk, arst_n, out_xfer && !out_data.last, out_data.byte_valid)
	// one item at a time: the block is busy right after taking one
	`OSDE_ASSERT_NXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind osd_screen_diff_spi_encoder osde_checker u_osde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: test/testbench.sv
module testbench;
	import osde_pkg::*;

	localparam int COLUMNS      = 30;
	localparam int ROWS_TALL    = 16;
	localparam int ROWS_SHORT   = 13;
	localparam int LAYERS       = 2;
	localparam int SCREEN_CELLS = COLUMNS * ROWS_TALL;
	localparam int SETTLE_CYCLES = 12;
	localparam int RUN_LIMIT    = 5_000_000;

	// command codes the block must ignore
	localparam logic [2:0] CMD_RSVD_LO = 3'd5;
	localparam logic [2:0] CMD_RSVD_HI = 3'd7;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	osde_in_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	osde_out_t  out_data;
	logic       cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;

	osd_screen_diff_spi_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// display model: layers, shadow of display memory, scan and run state
	logic [7:0]  layer_mem [LAYERS][SCREEN_CELLS];
	logic [7:0]  shadow_mem [SCREEN_CELLS];
	int unsigned scan_pos;
	bit          need_addr;
	bit          ai_on;
	bit          pal_tall;
	bit          layer_sel;
	logic [7:0]  base_mode;

	logic [7:0]  stream_bytes [$];
	osde_out_t   spi_expected [$];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int items_sent;
	int results_seen;
	int wraps_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("FAIL osd_screen_diff_spi_encoder");
		$finish;
	end

	function automatic int unsigned screen_len();
		return (pal_tall ? ROWS_TALL : ROWS_SHORT) * COLUMNS;
	endfunction

	function automatic void close_run();
		if (ai_on) begin
			if (!need_addr) begin
				stream_bytes.push_back(REG_DATA);
				stream_bytes.push_back(END_MARK);
			end
			stream_bytes.push_back(REG_MODE);
			stream_bytes.push_back(base_mode);
		end
		ai_on = 1'b0;
		need_addr = 1'b1;
	endfunction

	// works out the byte stream one command causes and queues it as transfers
	function automatic void encode_item(osde_in_t item);
		int unsigned size;
		int unsigned pos;
		int unsigned nxt;
		bit          next_diff;
		bit          wrapped;
		logic [7:0]  hi_byte;
		logic [7:0]  lo_byte;
		osde_out_t   r;
		size = screen_len();
		wrapped = 1'b0;
		stream_bytes.delete();
		case (item.command)
			CMD_WRITE: begin
				if (item.column < COLUMNS && item.row < ROWS_TALL)
					layer_mem[layer_sel][item.row * COLUMNS + item.column] = item.char_code;
			end
			CMD_SCAN: begin
				pos = scan_pos;
				if (pos >= SCREEN_CELLS)
					pos = 0;
				if (layer_mem[layer_sel][pos] != shadow_mem[pos]) begin
					if (layer_mem[layer_sel][pos] == END_MARK)
						layer_mem[layer_sel][pos] = SPACE_CHAR;
					if (need_addr || !ai_on) begin
						nxt = pos + 1;
						// lookahead beyond the screen counts as unchanged
						next_diff = 1'b0;
						if (nxt < size && nxt < SCREEN_CELLS)
							next_diff = layer_mem[layer_sel][nxt] != shadow_mem[nxt];
						hi_byte = 8'(pos >> 8);
						lo_byte = 8'(pos);
						stream_bytes.push_back(REG_MODE);
						stream_bytes.push_back(next_diff ? (base_mode | AUTO_INC_BIT) : base_mode);
						stream_bytes.push_back(REG_ADDR_HI);
						stream_bytes.push_back(hi_byte);
						stream_bytes.push_back(REG_ADDR_LO);
						stream_bytes.push_back(lo_byte);
						ai_on = next_diff;
						need_addr = 1'b0;
					end
					stream_bytes.push_back(REG_DATA);
					stream_bytes.push_back(layer_mem[layer_sel][pos]);
					shadow_mem[pos] = layer_mem[layer_sel][pos];
				end else if (!need_addr) begin
					need_addr = 1'b1;
					if (ai_on) begin
						stream_bytes.push_back(REG_DATA);
						stream_bytes.push_back(END_MARK);
					end
				end
				pos++;
				if (pos >= size) begin
					scan_pos = 0;
					close_run();
					wrapped = 1'b1;
					wraps_seen++;
				end else begin
					scan_pos = pos;
				end
			end
			CMD_END: close_run();
			CMD_CLR_SHADOW: begin
				for (int i = 0; i < size; i++)
					shadow_mem[i] = '0;
			end
			CMD_CLR_SCREEN: begin
				for (int i = 0; i < SCREEN_CELLS; i++)
					layer_mem[layer_sel][i] = SPACE_CHAR;
			end
			default: ;
		endcase
		if (stream_bytes.size() == 0) begin
			r = '0;
			r.last = 1'b1;
			r.scan_wrapped = wrapped;
			spi_expected.push_back(r);
		end else begin
			foreach (stream_bytes[i]) begin
				r.spi_byte = stream_bytes[i];
				r.byte_valid = 1'b1;
				r.last = (i == stream_bytes.size() - 1);
				r.scan_wrapped = wrapped;
				spi_expected.push_back(r);
			end
		end
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_transfer(input osde_out_t got);
		osde_out_t want;
		if (spi_expected.size() == 0) begin
			flag_mismatch($sformatf("transfer with nothing pending, byte %h", got.spi_byte));
			return;
		end
		want = spi_expected.pop_front();
		results_seen++;
		if (got.spi_byte !== want.spi_byte)
			flag_mismatch($sformatf("spi_byte %h, want %h", got.spi_byte, want.spi_byte));
		if (got.byte_valid !== want.byte_valid)
			flag_mismatch($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
		if (got.last !== want.last)
			flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
		if (got.scan_wrapped !== want.scan_wrapped)
			flag_mismatch($sformatf("scan_wrapped %b, want %b", got.scan_wrapped,
				want.scan_wrapped));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_transfer(out_data);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_item(input osde_in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		encode_item(item);
		items_sent++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// holds the sender until every queued byte has gone out and the block has settled
	task automatic drain_results();
		in_valid <= 1'b0;
		while (spi_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_PAL_MODE:     pal_tall = val[0];
			CFG_ACTIVE_LAYER: layer_sel = val[0];
			CFG_MODE_BITS:    base_mode = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	function automatic osde_in_t make_cmd(input logic [2:0] c);
		osde_in_t it;
		it.command = c;
		it.column = 5'($urandom_range(31));
		it.row = 5'($urandom_range(31));
		it.char_code = 8'($urandom_range(255));
		return it;
	endfunction

	function automatic osde_in_t make_write(input int unsigned col, input int unsigned row,
			input logic [7:0] ch);
		osde_in_t it;
		it.command = CMD_WRITE;
		it.column = 5'(col);
		it.row = 5'(row);
		it.char_code = ch;
		return it;
	endfunction

	// mix of unchanged cells, end marks and fresh codes so runs start and stop
	function automatic logic [7:0] fresh_char(input int unsigned p);
		int unsigned r;
		r = $urandom_range(7);
		if (r < 2)
			return shadow_mem[p];
		if (r == 2)
			return END_MARK;
		return 8'($urandom_range(255));
	endfunction

	function automatic osde_in_t random_item();
		int unsigned pick;
		int unsigned p;
		pick = $urandom_range(99);
		if (pick < 40) begin
			if ($urandom_range(3) != 0) begin
				// land just ahead of the scan so it finds differences
				p = (scan_pos + $urandom_range(6)) % SCREEN_CELLS;
				return make_write(p % COLUMNS, p / COLUMNS, fresh_char(p));
			end
			return make_cmd(CMD_WRITE);
		end
		if (pick < 80)
			return make_cmd(CMD_SCAN);
		if (pick < 88)
			return make_cmd(CMD_END);
		if (pick < 92)
			return make_cmd(CMD_CLR_SHADOW);
		if (pick < 95)
			return make_cmd(CMD_CLR_SCREEN);
		return make_cmd(3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)));
	endfunction

	// scans until the position reaches stop_at, sprinkling writes ahead of the scan;
	// steer_end arranges an unchanged cell then a changed last cell for the end lookahead
	task automatic scan_sweep(input int unsigned stop_at, input bit steer_end);
		int unsigned p;
		do begin
			if (steer_end && scan_pos == SCREEN_CELLS - 2) begin
				p = SCREEN_CELLS - 2;
				send_item(make_write(p % COLUMNS, p / COLUMNS, shadow_mem[p]));
				p = SCREEN_CELLS - 1;
				send_item(make_write(p % COLUMNS, p / COLUMNS, ~shadow_mem[p]));
			end else if ($urandom_range(7) == 0) begin
				p = (scan_pos + $urandom_range(3)) % SCREEN_CELLS;
				send_item(make_write(p % COLUMNS, p / COLUMNS, fresh_char(p)));
			end
			send_item(make_cmd(CMD_SCAN));
		end while (scan_pos != stop_at);
	endtask

	task automatic test_directed();
		set_idling(0, 0);
		write_reg(CFG_PAL_MODE, 8'h01);
		write_reg(CFG_ACTIVE_LAYER, 8'h00);
		write_reg(CFG_MODE_BITS, 8'hfe);
		for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++)
			send_item(make_cmd(3'(c)));
		// writes outside the grid are dropped
		send_item(make_write(31, 0, 8'h12));
		send_item(make_write(30, 15, 8'h34));
		send_item(make_write(0, 16, 8'h56));
		send_item(make_write(29, 31, 8'h78));
		send_item(make_write(0, 0, END_MARK));
		send_item(make_write(1, 0, 8'h41));
		send_item(make_write(29, 15, 8'h00));
		// stored end mark goes out as a space, opening an auto-increment run
		send_item(make_cmd(CMD_SCAN));
		send_item(make_cmd(CMD_SCAN));
		send_item(make_cmd(CMD_END));
		send_item(make_cmd(CMD_END));
		// single cell, then an unchanged cell with no run open
		send_item(make_write(3, 0, 8'h00));
		send_item(make_cmd(CMD_SCAN));
		send_item(make_cmd(CMD_SCAN));
		// run closed by an unchanged cell
		send_item(make_cmd(CMD_SCAN));
		send_item(make_write(7, 0, 8'h00));
		send_item(make_cmd(CMD_SCAN));
		send_item(make_cmd(CMD_SCAN));
		send_item(make_cmd(CMD_SCAN));
		send_item(make_cmd(CMD_CLR_SHADOW));
		send_item(make_cmd(CMD_CLR_SCREEN));
		drain_results();
	endtask

	task automatic test_random_mix();
		set_idling(45, 0);
		write_reg(CFG_ACTIVE_LAYER, 8'h01);
		write_reg(CFG_MODE_BITS, 8'($urandom_range(255)));
		repeat (65) send_item(random_item());
		drain_results();
		write_reg(CFG_PAL_MODE, 8'h00);
		write_reg(CFG_ACTIVE_LAYER, 8'h00);
		write_reg(CFG_MODE_BITS, 8'h00);
		repeat (65) send_item(random_item());
		drain_results();
	endtask

	task automatic test_tall_sweep();
		set_idling(0, 45);
		write_reg(CFG_PAL_MODE, 8'h01);
		write_reg(CFG_MODE_BITS, 8'hff);
		scan_sweep(0, 1'b1);
		drain_results();
	endtask

	task automatic test_short_wrap();
		set_idling(8, 8);
		write_reg(CFG_MODE_BITS, 8'($urandom_range(255)));
		scan_sweep($urandom_range(400, SCREEN_CELLS - 10), 1'b0);
		drain_results();
		// shrink the screen under the scan: the next scan still runs, then wraps
		write_reg(CFG_PAL_MODE, 8'h00);
		send_item(make_cmd(CMD_SCAN));
		send_item(make_cmd(CMD_CLR_SHADOW));
		repeat (12) send_item(random_item());
		drain_results();
	endtask

	initial begin
		for (int l = 0; l < LAYERS; l++)
			for (int i = 0; i < SCREEN_CELLS; i++)
				layer_mem[l][i] = SPACE_CHAR;
		for (int i = 0; i < SCREEN_CELLS; i++)
			shadow_mem[i] = '0;
		scan_pos = 0;
		need_addr = 1'b1;
		ai_on = 1'b0;
		pal_tall = 1'b1;
		layer_sel = 1'b0;
		base_mode = '0;
		set_idling(0, 0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_mix();
		test_tall_sweep();
		test_short_wrap();
		drain_results();
		$display("%0d commands sent, %0d output transfers checked, %0d screen wraps",
			items_sent, results_seen, wraps_seen);
		$display("both layers, tall and short screens, mode bytes 00/ff, random idling");
		if (mismatches == 0) begin
			$display("PASS osd_screen_diff_spi_encoder");
		end else begin
			$display("FAIL osd_screen_diff_spi_encoder");
		end
		$finish;
	end

endmodule
